/* hw/rtl/sst_pkg.sv */
package sst_pkg;

  // Table geometry.
  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = 32;
  localparam int PW    = 6;

  typedef struct packed {
    logic [1:0]           action;
    logic signed [WW-1:0] value;
  } sst_in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [PW-1:0] position;
  } sst_out_t;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_LINEAR = 2'd2,
    ACT_SORT   = 2'd3
  } sst_act_t;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2
  } sst_res_t;

  typedef enum logic [1:0] {
    POS_ZERO,
    POS_COUNT,
    POS_IDX,
    POS_MID
  } sst_pos_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_APPEND,
    OP_START,
    OP_LIN_RD,
    OP_LIN_NEXT,
    OP_SRT_LOAD_RD,
    OP_SRT_LOAD,
    OP_SRT_RD,
    OP_SRT_CMP,
    OP_SRT_END,
    OP_BIN_RD,
    OP_BIN_STEP
  } sst_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIN_RD,
    S_LIN_CHK,
    S_SRT_PASS,
    S_SRT_LOAD,
    S_SRT_RD,
    S_SRT_CMP,
    S_BIN_RD,
    S_BIN_CHK
  } sst_state_t;

  typedef struct packed {
    sst_op_t  op;
    logic     res_load;
    sst_res_t res_status;
    sst_pos_t pos_sel;
  } sst_cmd_t;

  typedef struct packed {
    logic full;
    logic lin_more;
    logic sort_more;
    logic step_more;
    logic bin_more;
    logic hit;
    logic key_less;
  } sst_stat_t;

endpackage

/* hw/rtl/sst_datapath.sv */
module sst_datapath
  import sst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sst_cmd_t             cmd,
  input  logic signed [WW-1:0] in_value,
  output sst_stat_t            stat,
  output sst_out_t             out_beat
);

  logic signed [WW-1:0] mem [DEPTH];

  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        lim_r, lim_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hiex_r, hiex_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic signed [WW-1:0] key_r, key_nxt;
  logic signed [WW-1:0] carry_r, carry_nxt;
  logic signed [WW-1:0] rdata_r;
  sst_out_t             res_r, res_nxt;

  logic [CW-1:0]        k_inc;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic                 rd_less;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic signed [WW-1:0] wdata;
  logic                 we;

  assign k_inc   = k_r + CW'(1);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hiex_r} - (CW + 1)'(1);
  assign mid     = mid_sum[CW:1];
  // The word just read is smaller than the running maximum of this pass.
  assign rd_less = rdata_r < carry_r;

  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.lin_more  = (k_r < count_r);
  assign stat.sort_more = (lim_r > CW'(1));
  assign stat.step_more = (k_inc < lim_r);
  assign stat.bin_more  = (lo_r < hiex_r);
  assign stat.hit       = (rdata_r == key_r);
  assign stat.key_less  = (rdata_r < key_r);

  assign out_beat = res_r;

  always_comb begin
    count_nxt = count_r;
    k_nxt     = k_r;
    lim_nxt   = lim_r;
    lo_nxt    = lo_r;
    hiex_nxt  = hiex_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    carry_nxt = carry_r;
    raddr     = '0;
    waddr     = k_r[AW-1:0];
    wdata     = carry_r;
    we        = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        count_nxt = '0;
      end
      OP_APPEND: begin
        we        = 1'b1;
        waddr     = count_r[AW-1:0];
        wdata     = in_value;
        count_nxt = count_r + CW'(1);
      end
      OP_START: begin
        key_nxt  = in_value;
        k_nxt    = '0;
        lim_nxt  = count_r;
        lo_nxt   = '0;
        hiex_nxt = count_r;
      end
      OP_LIN_RD: begin
        raddr = k_r[AW-1:0];
      end
      OP_LIN_NEXT: begin
        k_nxt = k_inc;
      end
      OP_SRT_LOAD_RD: begin
        raddr = '0;
        k_nxt = '0;
      end
      OP_SRT_LOAD: begin
        carry_nxt = rdata_r;
      end
      OP_SRT_RD: begin
        raddr = k_inc[AW-1:0];
      end
      OP_SRT_CMP: begin
        // The smaller word settles at k and the larger one travels on.
        we        = 1'b1;
        wdata     = rd_less ? rdata_r : carry_r;
        carry_nxt = rd_less ? carry_r : rdata_r;
        k_nxt     = k_inc;
      end
      OP_SRT_END: begin
        we      = 1'b1;
        wdata   = carry_r;
        lim_nxt = lim_r - CW'(1);
      end
      OP_BIN_RD: begin
        raddr   = mid[AW-1:0];
        mid_nxt = mid;
      end
      OP_BIN_STEP: begin
        if (stat.key_less) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hiex_nxt = mid_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.res_load) begin
      res_nxt.status = cmd.res_status;
      case (cmd.pos_sel)
        POS_COUNT: res_nxt.position = PW'(count_r);
        POS_IDX:   res_nxt.position = PW'(k_r);
        POS_MID:   res_nxt.position = PW'(mid_r);
        default:   res_nxt.position = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    lim_r   <= lim_nxt;
    lo_r    <= lo_nxt;
    hiex_r  <= hiex_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    carry_r <= carry_nxt;
    res_r   <= res_nxt;
  end

endmodule

/* hw/rtl/sst_controller.sv */
module sst_controller
  import sst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  sst_stat_t  stat,
  output sst_cmd_t   cmd
);

  sst_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd.op         = OP_IDLE;
    cmd.res_load   = 1'b0;
    cmd.res_status = RES_OK;
    cmd.pos_sel    = POS_ZERO;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_CLEAR: begin
              cmd.op       = OP_CLEAR;
              cmd.res_load = 1'b1;
            end
            ACT_APPEND: begin
              cmd.res_load = 1'b1;
              if (stat.full) begin
                cmd.res_status = RES_FULL;
              end else begin
                cmd.op      = OP_APPEND;
                cmd.pos_sel = POS_COUNT;
              end
            end
            ACT_LINEAR: begin
              cmd.op    = OP_START;
              state_nxt = S_LIN_RD;
            end
            default: begin
              cmd.op    = OP_START;
              state_nxt = S_SRT_PASS;
            end
          endcase
        end
      end
      S_LIN_RD: begin
        if (stat.lin_more) begin
          cmd.op    = OP_LIN_RD;
          state_nxt = S_LIN_CHK;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = RES_MISS;
          state_nxt      = S_IDLE;
        end
      end
      S_LIN_CHK: begin
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.pos_sel  = POS_IDX;
          state_nxt    = S_IDLE;
        end else begin
          cmd.op    = OP_LIN_NEXT;
          state_nxt = S_LIN_RD;
        end
      end
      S_SRT_PASS: begin
        if (stat.sort_more) begin
          cmd.op    = OP_SRT_LOAD_RD;
          state_nxt = S_SRT_LOAD;
        end else begin
          state_nxt = S_BIN_RD;
        end
      end
      S_SRT_LOAD: begin
        cmd.op    = OP_SRT_LOAD;
        state_nxt = S_SRT_RD;
      end
      S_SRT_RD: begin
        if (stat.step_more) begin
          cmd.op    = OP_SRT_RD;
          state_nxt = S_SRT_CMP;
        end else begin
          cmd.op    = OP_SRT_END;
          state_nxt = S_SRT_PASS;
        end
      end
      S_SRT_CMP: begin
        cmd.op    = OP_SRT_CMP;
        state_nxt = S_SRT_RD;
      end
      S_BIN_RD: begin
        if (stat.bin_more) begin
          cmd.op    = OP_BIN_RD;
          state_nxt = S_BIN_CHK;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = RES_MISS;
          state_nxt      = S_IDLE;
        end
      end
      S_BIN_CHK: begin
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.pos_sel  = POS_MID;
          state_nxt    = S_IDLE;
        end else begin
          cmd.op    = OP_BIN_STEP;
          state_nxt = S_BIN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/sort_and_search_table_unit.sv */
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   sst_in_t  {action, value}
// out_      output     out_valid / out_stall sst_out_t {status, position}
//
// Clear and append finish at the accept edge, where their result beat is registered.
// After the accept edge, linear search reads the entries in order and reports the first match, or a miss.
// Sort-search on n entries first bubble-sorts them in place, pass by pass, and then
// binary-searches them, one read and one compare per probe, bound by the single read port.
// Reset (rst_n low, synchronous) empties the table and drops any pending result beat.
// A beat is taken only while idle with the result register free or draining in that cycle.
module sort_and_search_table_unit
  import sst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sst_in_t  in_beat,
  output logic     out_valid,
  input  logic     out_stall,
  output sst_out_t out_beat
);

  sst_cmd_t  cmd;
  sst_stat_t stat;

  // The controller sequences each action; the datapath owns the table,
  // its element count, the search and sort indexes and the result register.
  sst_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_beat.action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sst_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_value (in_beat.value),
    .stat     (stat),
    .out_beat (out_beat)
  );

  // An append must never write beyond the last table entry.
  a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_APPEND |-> !stat.full)
    else $error("append issued on a full table");

  // A new result must never overwrite a beat that is still held.
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // A binary-search hit reports the probe that matched the key.
  a_mid_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load && cmd.pos_sel == POS_MID |-> stat.hit)
    else $error("midpoint reported without a match");

  // Once the result register is loaded, a beat is offered in the next cycle.
  a_result_offered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid)
    else $error("loaded result not offered");

endmodule

/* dv/sort_and_search_table_unit_tb.sv */
module sort_and_search_table_unit_tb
  import sst_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The receiver holds off for this many cycles at two points in the run. This
  // is long enough for the block to fill its result register and push back on
  // the sender.
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_REQUESTS = 1728;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sst_in_t  in_beat = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sst_out_t out_beat;

  sort_and_search_table_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Request beats that wait to be sent, and the answers that the block still
  // owes, oldest first.
  sst_in_t  queued_requests[$];
  sst_out_t awaited_answers[$];

  // The testbench's own copy of the table. It is updated only when a request
  // beat is accepted, so it always matches what the block should hold.
  logic signed [WW-1:0] shadow_words[DEPTH];
  int                   shadow_count = 0;

  // While the stimulus is built, this list follows which values the table will
  // hold, so that searches can be aimed at keys that are really present.
  logic signed [WW-1:0] held_values[$];

  int mismatches    = 0;
  int cycle_count   = 0;
  longint cycle_budget = 0;
  longint cycle_limit  = 64'd100_000_000;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Works out the one answer that a request beat causes, and updates the
  // shadow table the same way the block must. Sort-search bubble-sorts the
  // counted entries for good before the binary search, so later searches see
  // the sorted order.
  function automatic sst_out_t predict_answer(sst_in_t beat);
    sst_out_t             ans;
    logic signed [WW-1:0] key;
    logic signed [WW-1:0] swap_word;
    int                   lo;
    int                   hi;
    int                   mid;
    int                   k;
    int                   pass;
    key          = beat.value;
    ans.status   = RES_OK;
    ans.position = '0;
    case (sst_act_t'(beat.action))
      ACT_CLEAR: begin
        shadow_count = 0;
      end
      ACT_APPEND: begin
        if (shadow_count < DEPTH) begin
          shadow_words[shadow_count] = key;
          ans.position = PW'(shadow_count);
          shadow_count++;
        end else begin
          ans.status = RES_FULL;
        end
      end
      ACT_LINEAR: begin
        ans.status = RES_MISS;
        for (k = 0; k < shadow_count; k++) begin
          if (shadow_words[k] == key) begin
            ans.status   = RES_OK;
            ans.position = PW'(k);
            break;
          end
        end
      end
      default: begin
        for (pass = 0; pass + 1 < shadow_count; pass++) begin
          for (k = 0; k + 1 < shadow_count - pass; k++) begin
            if (shadow_words[k + 1] < shadow_words[k]) begin
              swap_word           = shadow_words[k];
              shadow_words[k]     = shadow_words[k + 1];
              shadow_words[k + 1] = swap_word;
            end
          end
        end
        ans.status = RES_MISS;
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (shadow_words[mid] == key) begin
            ans.status   = RES_OK;
            ans.position = PW'(mid);
            break;
          end
          if (shadow_words[mid] < key) lo = mid + 1;
          else hi = mid - 1;
        end
      end
    endcase
    return ans;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Data words lean toward the signed extremes and a narrow band around zero,
  // the latter so that duplicates turn up often.
  function automatic logic signed [WW-1:0] random_word();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return int'($urandom_range(16)) - 8;
      default: return $urandom();
    endcase
  endfunction

  // A search key: most of the time one that the table holds.
  function automatic logic signed [WW-1:0] pick_key();
    if (held_values.size() > 0 && $urandom_range(99) < 60)
      return held_values[$urandom_range(held_values.size() - 1)];
    return random_word();
  endfunction

  // Queues one request beat, follows its effect on the held values and adds
  // the worst case cost of the beat to the cycle budget. The cost covers the
  // block's own cycles plus the longest sender gap and receiver stall.
  task automatic queue_request(input sst_act_t act, input logic signed [WW-1:0] val);
    sst_in_t beat;
    int      held;
    longint  cost;
    held        = held_values.size();
    beat.action = act;
    beat.value  = val;
    queued_requests.push_back(beat);
    case (act)
      ACT_CLEAR: begin
        held_values.delete();
        cost = 2;
      end
      ACT_APPEND: begin
        if (held < DEPTH) held_values.push_back(val);
        cost = 2;
      end
      ACT_LINEAR: cost = 2 * held + 4;
      default:    cost = held * held + 2 * held + 24;
    endcase
    cycle_budget += cost + 130;
  endtask

  // Sender. A beat stays on the bus until it is taken; only then does the
  // driver move on, either to an idle gap or straight to the next beat. Every
  // accepted beat is run through the predictor at once, so the expected answers
  // line up in acceptance order.
  int send_gap  = 0;
  bit in_steady = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) awaited_answers.push_back(predict_answer(in_beat));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (queued_requests.size() > 0) begin
          in_valid <= 1'b1;
          in_beat  <= queued_requests.pop_front();
          if ($urandom_range(99) < 2) in_steady = !in_steady;
          send_gap = in_steady ? 0 : idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each answer beat taken is checked field by field against the
  // oldest expectation. The stall pattern mixes short and long stalls with
  // stretches of none, and twice the receiver holds off for a long time on its
  // own count of cycles while the sender keeps offering beats.
  int answers_seen = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit out_steady   = 1'b0;
  sst_out_t oldest;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("answer beat {status %0d, position %0d} with none owed",
                                    out_beat.status, out_beat.position));
        end else begin
          oldest = awaited_answers.pop_front();
          if (out_beat.status !== oldest.status)
            report_mismatch($sformatf("answer %0d: status %0d, wanted %0d",
                                      answers_seen, out_beat.status, oldest.status));
          if (out_beat.position !== oldest.position)
            report_mismatch($sformatf("answer %0d: position %0d, wanted %0d",
                                      answers_seen, out_beat.position, oldest.position));
        end
        if (answers_seen == 300 || answers_seen == 1000) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(199) == 0) out_steady = !out_steady;
        stall_left = out_steady ? 0 : idle_length();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Stops a run that hangs. The limit is several times the worst case budget
  // gathered while the stimulus was built.
  initial begin
    wait (cycle_count >= cycle_limit);
    $display("sort_and_search_table_unit_tb failed");
    $finish;
  end

  initial begin
    int       r;
    int       fill;
    int       rounds;
    int       searches;
    int       i;
    int       j;
    bit       first_fill;

    // Directed beats. Searches on an empty table come first, then a small
    // table with both signed extremes, zero, minus one and a duplicate pair.
    // Linear searches run on the order of appending, sort-searches reorder the
    // table for good, and a later linear search must see the sorted order. A
    // clear must hide the old words even though they stay in the memory.
    queue_request(ACT_LINEAR, 32'sd0);
    queue_request(ACT_SORT,   32'sd0);
    queue_request(ACT_CLEAR,  32'sd0);
    queue_request(ACT_APPEND, 32'sh7FFF_FFFF);
    queue_request(ACT_APPEND, 32'sh8000_0000);
    queue_request(ACT_APPEND, 32'sd0);
    queue_request(ACT_APPEND, -32'sd1);
    queue_request(ACT_APPEND, 32'sd5);
    queue_request(ACT_APPEND, 32'sd5);
    queue_request(ACT_LINEAR, 32'sd5);
    queue_request(ACT_LINEAR, 32'sh8000_0000);
    queue_request(ACT_LINEAR, 32'sd123);
    queue_request(ACT_SORT,   32'sh8000_0000);
    queue_request(ACT_SORT,   32'sd5);
    queue_request(ACT_SORT,   32'sh7FFF_FFFF);
    queue_request(ACT_SORT,   32'sd7);
    queue_request(ACT_LINEAR, -32'sd1);
    queue_request(ACT_CLEAR,  32'sh7FFF_FFFF);
    queue_request(ACT_LINEAR, -32'sd1);
    queue_request(ACT_APPEND, 32'sd3);
    queue_request(ACT_SORT,   32'sd3);
    queue_request(ACT_SORT,   32'sd4);

    // Random part. Most of it is well-formed sessions: an optional clear, a
    // fill, then rounds of searches with a few more appends in between. Tables
    // stay small most of the time since every sort-search costs a full bubble
    // sort. The first session and a few later ones append close to or past the table's
    // depth, so appends to a full table are refused at times. The rest is noise.
    first_fill = 1'b1;
    while (queued_requests.size() < RANDOM_REQUESTS) begin
      r = $urandom_range(99);
      if (r < 10) begin
        queue_request(sst_act_t'($urandom_range(3)), random_word());
      end else begin
        if (first_fill || r < 13) fill = $urandom_range(70, 60);
        else if (r < 20) fill = $urandom_range(40, 13);
        else fill = $urandom_range(12);
        first_fill = 1'b0;
        if ($urandom_range(3) != 0) queue_request(ACT_CLEAR, random_word());
        rounds = $urandom_range(3, 1);
        for (i = 0; i < rounds; i++) begin
          if (i > 0) fill = $urandom_range(3);
          for (j = 0; j < fill; j++)
            queue_request(ACT_APPEND, ($urandom_range(3) == 0) ? pick_key() : random_word());
          searches = $urandom_range(3, 1);
          for (j = 0; j < searches; j++)
            queue_request($urandom_range(1) ? ACT_LINEAR : ACT_SORT, pick_key());
        end
      end
    end
    cycle_limit = 3 * (cycle_budget + 2 * HOLD_CYCLES) + 20_000;

    // Reset is held once, at the start of the run.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Every beat sent, every answer back, then a short drain to catch any
    // stray answer beat. The check runs at the falling edge, when the sender
    // and the receiver have both settled.
    while (queued_requests.size() > 0 || in_valid !== 1'b0 ||
           awaited_answers.size() > 0) @(negedge clk);
    repeat (50) @(posedge clk);
    while (awaited_answers.size() > 0) begin
      oldest = awaited_answers.pop_front();
      report_mismatch($sformatf("answer {status %0d, position %0d} never arrived",
                                oldest.status, oldest.position));
    end

    if (mismatches == 0) begin
      $display("sort_and_search_table_unit_tb passed");
    end else begin
      $display("sort_and_search_table_unit_tb failed");
    end
    $finish;
  end

endmodule
